// ----- hw/rtl/oneshot_periodic_timer_table_defines.svh -----
// Assertion macros shared by the checker of the timer table.
`ifndef ONESHOT_PERIODIC_TIMER_TABLE_DEFINES_SVH
`define ONESHOT_PERIODIC_TIMER_TABLE_DEFINES_SVH

// Whenever cond holds at a clock edge, prop must hold at the same edge.
`define OPTT_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("timer table: implication violated");

// A stalled transaction keeps its valid and its payload.
`define OPTT_ASSERT_HOLD(label, clk, rst_n, vld, rdy, a, b, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(a) && $stable(b) && $stable(c))) \
        else $error("timer table: stalled transaction changed");

`endif

// ----- hw/rtl/optt_pkg.sv -----
package optt_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int MAX_FIRE    = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int TIME_W      = 48;
    localparam int DELAY_W     = 32;
    localparam int ID_W        = 16;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 2;
    localparam int FIRE_W      = $clog2(MAX_FIRE + 1);

    localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHED_ONE = 2'd1;
    localparam logic [OP_W-1:0] OP_SCHED_PER = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd3;

    localparam logic [KIND_W-1:0] KIND_ASSIGNED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [TIME_W-1:0]  now;
        logic [DELAY_W-1:0] delay;
        logic [TIME_W-1:0]  due;
    } t_cmd;

    typedef struct packed {
        logic               periodic;
        logic [TIME_W-1:0]  due;
        logic [DELAY_W-1:0] period;
        logic [ID_W-1:0]    ident;
    } t_entry;

    // Time plus delay, saturating at the largest representable time.
    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [DELAY_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = {1'b0, a} + {{(TIME_W + 1 - DELAY_W){1'b0}}, b};
        return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/oneshot_periodic_timer_table.sv -----
// A schedule result passes the front register, the command queue and the output register.
// Schedule and clear are done from the idle state of the table engine; a tick walks the N
// stored entries, one memory read per entry, and can be held by any output stall.
// A four-deep command queue lets the input side run ahead while a tick is walked.
// Reset is synchronous and active low: the table is emptied and the id counter set to zero.
module oneshot_periodic_timer_table #(
    parameter int SLOTS = optt_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [optt_pkg::OP_W-1:0]     i_operation,
    input  logic [optt_pkg::TIME_W-1:0]   i_now_ms,
    input  logic [optt_pkg::DELAY_W-1:0]  i_delay_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [optt_pkg::KIND_W-1:0]   o_kind,
    output logic [optt_pkg::ID_W-1:0]     o_task_id,
    output logic                          o_last
);
    import optt_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_cmd front_cmd;
    t_cmd head_cmd;

    optt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_operation),
        .i_now_ms    (i_now_ms),
        .i_delay_ms  (i_delay_ms),
        .o_push      (push),
        .o_cmd       (front_cmd),
        .i_full      (full)
    );

    optt_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (empty)
    );

    optt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_task_id   (o_task_id),
        .o_last      (o_last)
    );

endmodule

// ----- hw/rtl/optt_front.sv -----
module optt_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [optt_pkg::OP_W-1:0]     i_operation,
    input  logic [optt_pkg::TIME_W-1:0]   i_now_ms,
    input  logic [optt_pkg::DELAY_W-1:0]  i_delay_ms,
    output logic                          o_push,
    output optt_pkg::t_cmd                o_cmd,
    input  logic                          i_full
);
    import optt_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // The due time of a schedule is worked out here, off the table engine's path.
    always_comb begin
        n_cmd.op    = i_operation;
        n_cmd.now   = i_now_ms;
        n_cmd.delay = i_delay_ms;
        n_cmd.due   = sat_add(i_now_ms, i_delay_ms);
    end

    assign o_in_ready = !r_valid || !i_full;
    assign o_push     = r_valid && !i_full;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- hw/rtl/optt_fifo.sv -----
module optt_fifo #(
    parameter int DEPTH = optt_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  optt_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output optt_pkg::t_cmd o_data,
    output logic           o_empty
);
    import optt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/optt_back.sv -----
module optt_back #(
    parameter int SLOTS = optt_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  optt_pkg::t_cmd               i_cmd,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [optt_pkg::KIND_W-1:0]  o_kind,
    output logic [optt_pkg::ID_W-1:0]    o_task_id,
    output logic                         o_last
);
    import optt_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    t_entry              r_mem [SLOTS];
    t_entry              r_rd_data;
    logic [1:0]          r_state,      n_state;
    logic [CNT_W-1:0]    r_count,      n_count;
    logic [ID_W-1:0]     r_next_id,    n_next_id;
    logic [CNT_W-1:0]    r_eval,       n_eval;
    logic [CNT_W-1:0]    r_wr,         n_wr;
    logic [FIRE_W-1:0]   r_fired,      n_fired;
    logic                r_hold_valid, n_hold_valid;
    logic [ID_W-1:0]     r_hold_id,    n_hold_id;
    logic [TIME_W-1:0]   r_now,        n_now;
    logic                r_o_valid;
    logic [KIND_W-1:0]   r_o_kind;
    logic [ID_W-1:0]     r_o_id;
    logic                r_o_last;

    logic                out_free;
    logic                due_hit;
    logic                advance;
    logic [CNT_W-1:0]    eval_next;
    logic [CNT_W-1:0]    rd_sel;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    t_entry              wr_data;
    t_entry              rearm;
    logic                emit;
    logic [KIND_W-1:0]   emit_kind;
    logic [ID_W-1:0]     emit_id;
    logic                emit_last;

    assign out_free  = !r_o_valid || i_out_ready;
    assign due_hit   = (r_now >= r_rd_data.due) && (r_fired != FIRE_W'(MAX_FIRE));
    assign advance   = !(due_hit && r_hold_valid && !out_free);
    assign eval_next = r_eval + 1'b1;
    assign rd_addr   = (rd_sel >= CNT_W'(SLOTS)) ? '0 : rd_sel[IDX_W-1:0];

    always_comb begin
        rearm     = r_rd_data;
        rearm.due = sat_add(r_now, r_rd_data.period);
    end

    // A fired entry is held back one step so that the last one can be flagged.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_next_id    = r_next_id;
        n_eval       = r_eval;
        n_wr         = r_wr;
        n_fired      = r_fired;
        n_hold_valid = r_hold_valid;
        n_hold_id    = r_hold_id;
        n_now        = r_now;
        o_pop        = 1'b0;
        emit         = 1'b0;
        emit_kind    = KIND_ASSIGNED;
        emit_id      = '0;
        emit_last    = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_wr[IDX_W-1:0];
        wr_data      = r_rd_data;
        rd_sel       = r_eval;
        case (r_state)
            ST_IDLE: begin
                rd_sel = '0;
                if (!i_empty) begin
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            o_pop     = 1'b1;
                            n_count   = '0;
                            n_next_id = '0;
                        end
                        OP_SCHED_ONE, OP_SCHED_PER: begin
                            if (out_free) begin
                                o_pop     = 1'b1;
                                emit      = 1'b1;
                                emit_last = 1'b1;
                                if (r_count == CNT_W'(SLOTS)) begin
                                    emit_kind = KIND_FULL;
                                end else begin
                                    emit_kind        = KIND_ASSIGNED;
                                    emit_id          = r_next_id;
                                    wr_en            = 1'b1;
                                    wr_addr          = r_count[IDX_W-1:0];
                                    wr_data.periodic = (i_cmd.op == OP_SCHED_PER);
                                    wr_data.due      = i_cmd.due;
                                    wr_data.period   = i_cmd.delay;
                                    wr_data.ident    = r_next_id;
                                    n_count          = r_count + 1'b1;
                                    n_next_id        = r_next_id + 1'b1;
                                end
                            end
                        end
                        default: begin
                            o_pop        = 1'b1;
                            n_now        = i_cmd.now;
                            n_eval       = '0;
                            n_wr         = '0;
                            n_fired      = '0;
                            n_hold_valid = 1'b0;
                            n_state      = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_eval == r_count) begin
                    n_state = ST_FINISH;
                end else begin
                    rd_sel = advance ? eval_next : r_eval;
                    if (advance) begin
                        n_eval = eval_next;
                        if (due_hit) begin
                            n_fired      = r_fired + 1'b1;
                            n_hold_valid = 1'b1;
                            n_hold_id    = r_rd_data.ident;
                            if (r_hold_valid) begin
                                emit      = 1'b1;
                                emit_kind = KIND_FIRED;
                                emit_id   = r_hold_id;
                            end
                            if (r_rd_data.periodic) begin
                                wr_en   = 1'b1;
                                wr_data = rearm;
                                n_wr    = r_wr + 1'b1;
                            end
                        end else begin
                            wr_en = 1'b1;
                            n_wr  = r_wr + 1'b1;
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (!r_hold_valid) begin
                    n_count = r_wr;
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    emit         = 1'b1;
                    emit_kind    = KIND_FIRED;
                    emit_id      = r_hold_id;
                    emit_last    = 1'b1;
                    n_hold_valid = 1'b0;
                    n_count      = r_wr;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_next_id    <= '0;
            r_eval       <= '0;
            r_wr         <= '0;
            r_fired      <= '0;
            r_hold_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_next_id    <= n_next_id;
            r_eval       <= n_eval;
            r_wr         <= n_wr;
            r_fired      <= n_fired;
            r_hold_valid <= n_hold_valid;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_id <= n_hold_id;
        r_now     <= n_now;
        if (emit) begin
            r_o_kind <= emit_kind;
            r_o_id   <= emit_id;
            r_o_last <= emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_task_id   = r_o_id;
    assign o_last      = r_o_last;

endmodule

// ----- hw/rtl/optt_checker.sv -----
`include "oneshot_periodic_timer_table_defines.svh"

module optt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [optt_pkg::KIND_W-1:0] o_kind,
    input logic [optt_pkg::ID_W-1:0]   o_task_id,
    input logic                        o_last
);
    import optt_pkg::*;

    `OPTT_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_out_valid, i_out_ready, o_kind, o_task_id, o_last)
    `OPTT_ASSERT_IMPLY(a_kind_legal, i_clk, i_rst_n, o_out_valid, (o_kind == KIND_ASSIGNED) || (o_kind == KIND_FIRED) || (o_kind == KIND_FULL))
    `OPTT_ASSERT_IMPLY(a_sched_last, i_clk, i_rst_n, o_out_valid && (o_kind != KIND_FIRED), o_last)
    `OPTT_ASSERT_IMPLY(a_full_id_zero, i_clk, i_rst_n, o_out_valid && (o_kind == KIND_FULL), o_task_id == '0)

endmodule

bind oneshot_periodic_timer_table optt_checker u_optt_checker (.*);
